/* sv/fcsg_pkg.sv */
// Shared types and constants of the filled circle span generator.
package fcsg_pkg;

  localparam int OFS_W  = 7;
  localparam int DEC_W  = 9;
  localparam int RAD_W  = 6;
  localparam int SCR_W  = 12;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 12'd1440;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 12'd810;

  typedef struct packed {
    logic [OFS_W-1:0]        across;
    logic [OFS_W-1:0]        down;
    logic signed [DEC_W-1:0] decision;
    logic                    last;
  } walk_t;

endpackage

/* sv/fcsg_step.sv */
// Circle walk unit: one decision update of the scan per use.
module fcsg_step import fcsg_pkg::*; (
  input  logic [OFS_W-1:0]        across,
  input  logic [OFS_W-1:0]        down,
  input  logic signed [DEC_W-1:0] decision,
  input  logic [RAD_W-1:0]        radius,
  output walk_t                   nxt
);

  logic signed [DEC_W:0] dec_ext;
  logic signed [DEC_W:0] across_x2;
  logic signed [DEC_W:0] down_x2;
  logic signed [DEC_W:0] gap_x2;
  logic signed [DEC_W:0] dec_sum;
  logic [OFS_W-1:0]      across_sum;
  logic [OFS_W:0]        down_sum;

  always_comb begin
    dec_ext   = {decision[DEC_W-1], decision};
    across_x2 = signed'({{(DEC_W-OFS_W){1'b0}}, across, 1'b0});
    down_x2   = signed'({{(DEC_W-OFS_W){1'b0}}, down, 1'b0});
    gap_x2    = signed'({{(DEC_W-RAD_W){1'b0}}, radius, 1'b0}) - down_x2;
    if (dec_ext >= across_x2) begin
      dec_sum    = dec_ext - across_x2 - (DEC_W+1)'(1);
      across_sum = across + OFS_W'(1);
      down_sum   = {1'b0, down};
    end else if (dec_ext < gap_x2) begin
      dec_sum    = dec_ext + down_x2 - (DEC_W+1)'(1);
      across_sum = across;
      down_sum   = {1'b0, down} - (OFS_W+1)'(1);
    end else begin
      dec_sum    = dec_ext + down_x2 - across_x2 - (DEC_W+1)'(2);
      across_sum = across + OFS_W'(1);
      down_sum   = {1'b0, down} - (OFS_W+1)'(1);
    end
    nxt.across   = across_sum;
    nxt.down     = down_sum[OFS_W-1:0];
    nxt.decision = dec_sum[DEC_W-1:0];
    nxt.last     = signed'(down_sum) < signed'({1'b0, across_sum});
  end

endmodule

/* sv/filled_circle_span_generator.sv */
// Filled circle span generator: circle request in, one set of four spans per cycle out
// while out_stall is low. An accepted request loads the walk state registers, and each
// result of the walk unit is then registered in the output registers. A new request is
// taken only after the last result of the previous circle has been loaded.
// in_stall stays high while a circle is walked; output stalls hold the walk.
// Reset (synchronous, rst_n low) clears the walk and output valid and restores screen size.
module filled_circle_span_generator import fcsg_pkg::*; #(
  parameter int MAX_RADIUS = 63,
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_BITS-1:0]  in_center_x,
  input  logic [COORD_BITS-1:0]  in_center_y,
  input  logic [RAD_W-1:0]       in_circle_radius,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_BITS:0]    out_wide_left_x,
  output logic [COORD_BITS:0]    out_wide_right_x,
  output logic [COORD_BITS:0]    out_wide_lower_row,
  output logic [COORD_BITS:0]    out_wide_upper_row,
  output logic [COORD_BITS:0]    out_narrow_left_x,
  output logic [COORD_BITS:0]    out_narrow_right_x,
  output logic [COORD_BITS:0]    out_narrow_lower_row,
  output logic [COORD_BITS:0]    out_narrow_upper_row,
  output logic                   out_visible,
  output logic                   out_last_span_set,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int CW  = COORD_BITS + 1;
  localparam int CMP_W = (COORD_BITS > SCR_W) ? COORD_BITS : SCR_W;
  localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);

  logic                    busy_r, busy_nxt;
  logic [OFS_W-1:0]        across_r, across_nxt;
  logic [OFS_W-1:0]        down_r, down_nxt;
  logic signed [DEC_W-1:0] dec_r, dec_nxt;
  logic [COORD_BITS-1:0]   cx_r, cx_nxt;
  logic [COORD_BITS-1:0]   cy_r, cy_nxt;
  logic [RAD_W-1:0]        rad_r, rad_nxt;
  logic [SCR_W-1:0]        width_r, width_nxt;
  logic [SCR_W-1:0]        height_r, height_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CW-1:0]           wl_r, wr_r, wlo_r, wup_r, nl_r, nr_r, nlo_r, nup_r;
  logic                    vis_r, last_r;

  walk_t          step;
  logic           accept;
  logic           load_out;
  logic           cfg_wr;
  logic [RAD_W-1:0] rad_sat;
  logic [CW-1:0]  cx_e, cy_e, a_e, d_e;
  logic [CW-1:0]  px, py;
  logic           vis;

  fcsg_step u_step (
    .across   (across_r),
    .down     (down_r),
    .decision (dec_r),
    .radius   (rad_r),
    .nxt      (step)
  );

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign load_out = busy_r && (!out_valid_r || !out_stall);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign rad_sat  = (in_circle_radius > RAD_MAX) ? RAD_MAX : in_circle_radius;

  assign cx_e = {cx_r[COORD_BITS-1], cx_r};
  assign cy_e = {cy_r[COORD_BITS-1], cy_r};
  assign a_e  = CW'(across_r);
  assign d_e  = CW'(down_r);
  assign px   = cx_e + a_e;
  assign py   = cy_e + d_e;
  assign vis  = !px[CW-1] && (CMP_W'(px[CW-2:0]) < CMP_W'(width_r)) &&
                !py[CW-1] && (CMP_W'(py[CW-2:0]) < CMP_W'(height_r));

  always_comb begin
    case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = DATA_W'(width_r);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(height_r);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_SCREEN_WIDTH:  width_nxt  = pwdata[SCR_W-1:0];
        REG_SCREEN_HEIGHT: height_nxt = pwdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    across_nxt = across_r;
    down_nxt   = down_r;
    dec_nxt    = dec_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rad_nxt    = rad_r;
    if (accept) begin
      busy_nxt   = 1'b1;
      across_nxt = '0;
      down_nxt   = OFS_W'(rad_sat);
      dec_nxt    = DEC_W'(rad_sat) - DEC_W'(1);
      cx_nxt     = in_center_x;
      cy_nxt     = in_center_y;
      rad_nxt    = rad_sat;
    end else if (load_out) begin
      busy_nxt   = !step.last;
      across_nxt = step.across;
      down_nxt   = step.down;
      dec_nxt    = step.decision;
    end
    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      across_r    <= '0;
      down_r      <= '0;
      dec_r       <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      rad_r       <= '0;
      width_r     <= SCREEN_WIDTH_RST;
      height_r    <= SCREEN_HEIGHT_RST;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      across_r    <= across_nxt;
      down_r      <= down_nxt;
      dec_r       <= dec_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      rad_r       <= rad_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      wl_r   <= cx_e - d_e;
      wr_r   <= cx_e + d_e;
      wlo_r  <= cy_e + a_e;
      wup_r  <= cy_e - a_e;
      nl_r   <= cx_e - a_e;
      nr_r   <= px;
      nlo_r  <= py;
      nup_r  <= cy_e - d_e;
      vis_r  <= vis;
      last_r <= step.last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_wide_left_x      = wl_r;
  assign out_wide_right_x     = wr_r;
  assign out_wide_lower_row   = wlo_r;
  assign out_wide_upper_row   = wup_r;
  assign out_narrow_left_x    = nl_r;
  assign out_narrow_right_x   = nr_r;
  assign out_narrow_lower_row = nlo_r;
  assign out_narrow_upper_row = nup_r;
  assign out_visible          = vis_r;
  assign out_last_span_set    = last_r;

endmodule

/* sv/fcsg_checker.sv */
// Port-level checks of the filled circle span generator and their binding.
module fcsg_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS:0]   out_wide_left_x,
  input logic [COORD_BITS:0]   out_narrow_upper_row,
  input logic                  out_last_span_set
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wide_left_x) &&
      $stable(out_narrow_upper_row) && $stable(out_last_span_set))
    else $error("stalled transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_span_set |-> in_stall)
    else $error("circle walk ended before its last transaction");

endmodule

bind filled_circle_span_generator fcsg_checker #(.COORD_BITS(COORD_BITS)) u_fcsg_checker (.*);
